@@ rtl/tccw_pkg.sv @@
// Shared types and constants of the terminal character-cell writer.
package tccw_pkg;

  // Request codes on the input channel.
  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_FG   = 2'd1;
  localparam logic [1:0] REQ_BG   = 2'd2;
  localparam logic [1:0] REQ_READ = 2'd3;

  // Single-byte control characters.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // UTF-8 lead and continuation masks.
  localparam logic [7:0] U8_CONT_MASK = 8'hc0;
  localparam logic [7:0] U8_CONT_VAL  = 8'h80;
  localparam logic [7:0] U8_LEAD2_MSK = 8'he0;
  localparam logic [7:0] U8_LEAD2_VAL = 8'hc0;
  localparam logic [7:0] U8_LEAD3_MSK = 8'hf0;
  localparam logic [7:0] U8_LEAD3_VAL = 8'he0;

  // Largest number of visible rows.
  localparam logic [6:0] VIS_ROW_LIMIT = 7'd64;

  // Register indexes of the configuration port.
  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;

  // One stored character cell.
  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  len;
    logic [7:0]  fg;
    logic [7:0]  bg;
    logic        chg;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_DEC,
    S_RDW,
    S_CWR,
    S_NLRD,
    S_NLWR,
    S_DONE
  } state_t;

endpackage

@@ rtl/text_cell_canvas_writer.sv @@
// Character-cell writer: UTF-8 assembly, cell ring memory and its control sequencer.
//
// Requests enter on in_valid/in_stall: an output byte, a foreground or
// background colour set, or a cell read. Every request gives exactly one
// result on out_valid/out_stall, carrying the cursor after the request and,
// for a read, the stored cell. One request is worked on at a time; the cell
// memory is a single-port-read array, so a colour set reads its cell, waits
// for the data and writes back, and a newline rewrites its row one cell at a
// time (read, then write). A new request is taken in the cycle after the
// result is loaded.
// After reset the block sweeps the cell memory and row marks to zero, one
// cell per cycle, over all HISTORY_ROWS * MAX_COLS cells; in_stall stays high
// meanwhile, while the configuration port is taken as ever.
// A result waits in the output register while out_stall is high; the next
// request may be accepted, but its result is held back until the register
// is free.
module text_cell_canvas_writer #(
  parameter int HISTORY_ROWS = 512,
  parameter int MAX_COLS     = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_color,
  input  logic [5:0]  in_read_row,
  input  logic [6:0]  in_read_col,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_cell_bytes,
  output logic [2:0]  out_cell_length,
  output logic [7:0]  out_cell_fg,
  output logic [7:0]  out_cell_bg,
  output logic        out_cell_changed,
  output logic        out_row_changed,
  output logic [5:0]  out_cursor_row,
  output logic [6:0]  out_cursor_col,
  output logic        out_bad_sequence,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  import tccw_pkg::*;

  localparam int DEPTH = HISTORY_ROWS * MAX_COLS;
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(HISTORY_ROWS);
  localparam int AW    = $clog2(DEPTH);
  localparam int ECW   = $clog2(MAX_COLS + 1);

  // Ring row of a screen row.
  function automatic logic [RW-1:0] ring_of(input logic [RW-1:0] start,
                                            input logic [5:0] row);
    logic [RW:0] sum;
    sum = {1'b0, start} + (RW+1)'(row);
    if (sum >= (RW+1)'(HISTORY_ROWS)) begin
      sum = sum - (RW+1)'(HISTORY_ROWS);
    end
    return sum[RW-1:0];
  endfunction

  // Cell address of a ring row and column.
  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] rr,
                                              input logic [CW-1:0] col);
    return AW'(rr) * AW'(MAX_COLS) + AW'(col);
  endfunction

  state_t          state_r, state_nxt;
  logic [7:0]      cols_r;
  logic [6:0]      rows_r;
  logic [RW-1:0]   ring_r, ring_nxt;
  logic [5:0]      cur_row_r, cur_row_nxt;
  logic [CW-1:0]   cur_col_r, cur_col_nxt;
  logic [7:0]      pen_fg_r, pen_fg_nxt;
  logic [7:0]      pen_bg_r, pen_bg_nxt;
  logic [23:0]     seq_bytes_r, seq_bytes_nxt;
  logic [2:0]      seq_exp_r, seq_exp_nxt;
  logic [2:0]      seq_rec_r, seq_rec_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [ECW-1:0]  nl_j_r, nl_j_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [RW-1:0]   drow_r, drow_nxt;
  logic            rd_ok_r, rd_ok_nxt;

  // Latched request.
  logic [1:0]      q_type_r;
  logic [7:0]      q_data_r;
  logic [7:0]      q_color_r;
  logic [5:0]      q_row_r;
  logic [6:0]      q_col_r;

  // Pending result.
  cell_t           res_cell_r, res_cell_nxt;
  logic            res_rowchg_r, res_rowchg_nxt;
  logic            res_bad_r, res_bad_nxt;

  // Output register.
  logic            out_valid_r, out_valid_nxt;
  cell_t           out_cell_r, out_cell_nxt;
  logic            out_rowchg_r, out_rowchg_nxt;
  logic            out_bad_r, out_bad_nxt;
  logic [5:0]      out_row_r, out_row_nxt;
  logic [6:0]      out_col_r, out_col_nxt;

  // Memory ports.
  logic            cell_we;
  logic [AW-1:0]   cell_waddr, cell_raddr;
  cell_t           cell_wdata, cell_rdata;
  logic [CELL_W-1:0] cell_rdata_raw;
  logic            dirty_we;
  logic [RW-1:0]   dirty_waddr, dirty_raddr;
  logic            dirty_wdata, dirty_rdata;

  // Derived screen size and clamped cursor.
  logic [8:0]      eff_cols;
  logic [6:0]      eff_rows;
  logic [CW-1:0]   ccol;
  logic [5:0]      crow;
  logic [RW-1:0]   ring_inc;
  logic [8:0]      col_inc;
  logic [6:0]      row_inc;
  logic            scroll;
  logic [5:0]      nr_row;
  logic [RW-1:0]   nr_ring;
  logic [RW-1:0]   g_ring_row;
  logic [AW-1:0]   g_addr;
  logic [31:0]     comp_bytes;
  logic [8:0]      rcol_ext;
  logic [AW-1:0]   nl_addr;
  logic            accept;
  logic            out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Effective sizes after range limiting.
  always_comb begin
    if (cols_r == 8'd0) begin
      eff_cols = 9'd1;
    end else if ({1'b0, cols_r} > 9'(MAX_COLS)) begin
      eff_cols = 9'(MAX_COLS);
    end else begin
      eff_cols = {1'b0, cols_r};
    end
    if (rows_r == 7'd0) begin
      eff_rows = 7'd1;
    end else if (rows_r > VIS_ROW_LIMIT) begin
      eff_rows = VIS_ROW_LIMIT;
    end else begin
      eff_rows = rows_r;
    end
  end

  // Cursor clamping, glyph advance and the next-row step.
  always_comb begin
    ccol = (9'(cur_col_r) >= eff_cols) ? CW'(eff_cols - 9'd1) : cur_col_r;
    crow = (7'(cur_row_r) >= eff_rows) ? 6'(eff_rows - 7'd1) : cur_row_r;
    ring_inc = (ring_r == RW'(HISTORY_ROWS - 1)) ? '0 : ring_r + RW'(1);
    col_inc  = 9'(ccol) + 9'd1;
    row_inc  = 7'(crow) + 7'd1;
    scroll   = (row_inc >= eff_rows);
    nr_row   = scroll ? 6'(eff_rows - 7'd1) : 6'(row_inc);
    nr_ring  = scroll ? ring_inc : ring_r;
    g_ring_row = ring_of(ring_r, crow);
    g_addr     = cell_addr(g_ring_row, ccol);
    comp_bytes = {8'd0, seq_bytes_r} | (32'(q_data_r) << {seq_rec_r[1:0], 3'b000});
    rcol_ext   = 9'(q_col_r);
    nl_addr    = cell_addr(ring_of(ring_r, cur_row_r), CW'(nl_j_r));
  end

  // Sequencer: next state, memory accesses and register updates.
  always_comb begin
    state_nxt      = state_r;
    ring_nxt       = ring_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    pen_fg_nxt     = pen_fg_r;
    pen_bg_nxt     = pen_bg_r;
    seq_bytes_nxt  = seq_bytes_r;
    seq_exp_nxt    = seq_exp_r;
    seq_rec_nxt    = seq_rec_r;
    clr_nxt        = clr_r;
    nl_j_nxt       = nl_j_r;
    addr_nxt       = addr_r;
    drow_nxt       = drow_r;
    rd_ok_nxt      = rd_ok_r;
    res_cell_nxt   = res_cell_r;
    res_rowchg_nxt = res_rowchg_r;
    res_bad_nxt    = res_bad_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_cell_nxt   = out_cell_r;
    out_rowchg_nxt = out_rowchg_r;
    out_bad_nxt    = out_bad_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    cell_we        = 1'b0;
    cell_waddr     = addr_r;
    cell_wdata     = '0;
    cell_raddr     = addr_r;
    dirty_we       = 1'b0;
    dirty_waddr    = drow_r;
    dirty_wdata    = 1'b1;
    dirty_raddr    = drow_r;

    case (state_r)
      S_CLR: begin
        // Sweep the memories to zero after reset.
        cell_we     = 1'b1;
        cell_waddr  = clr_r;
        dirty_we    = (clr_r < AW'(HISTORY_ROWS));
        dirty_waddr = RW'(clr_r);
        dirty_wdata = 1'b0;
        clr_nxt     = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        res_cell_nxt   = '0;
        res_rowchg_nxt = 1'b0;
        res_bad_nxt    = 1'b0;
        state_nxt      = S_DONE;
        if (q_type_r == REQ_READ) begin
          // Cell read: fetch the cell and its row mark.
          rd_ok_nxt   = (rcol_ext < 9'(MAX_COLS));
          drow_nxt    = ring_of(ring_r, q_row_r);
          addr_nxt    = cell_addr(ring_of(ring_r, q_row_r), CW'(q_col_r));
          cell_raddr  = addr_nxt;
          dirty_raddr = drow_nxt;
          state_nxt   = S_RDW;
        end else begin
          cur_row_nxt = crow;
          cur_col_nxt = ccol;
          if (q_type_r == REQ_BYTE) begin
            if (seq_exp_r == 3'd0) begin
              if (q_data_r < U8_CONT_VAL) begin
                case (q_data_r)
                  CH_NUL, CH_BEL, CH_TAB, CH_ESC: begin
                  end
                  CH_BS: begin
                    if (ccol != '0) begin
                      cur_col_nxt = ccol - CW'(1);
                    end
                  end
                  CH_CR: begin
                    cur_col_nxt = '0;
                  end
                  CH_LF: begin
                    cur_col_nxt = '0;
                    cur_row_nxt = nr_row;
                    ring_nxt    = nr_ring;
                    nl_j_nxt    = '0;
                    state_nxt   = S_NLRD;
                  end
                  default: begin
                    cell_we     = 1'b1;
                    cell_waddr  = g_addr;
                    cell_wdata  = '{bytes: 32'(q_data_r), len: 3'd1, fg: pen_fg_r,
                                    bg: pen_bg_r, chg: 1'b1};
                    dirty_we    = 1'b1;
                    dirty_waddr = g_ring_row;
                    if (col_inc >= eff_cols) begin
                      cur_col_nxt = '0;
                      cur_row_nxt = nr_row;
                      ring_nxt    = nr_ring;
                    end else begin
                      cur_col_nxt = CW'(col_inc);
                    end
                  end
                endcase
              end else begin
                // Lead byte opens a sequence.
                if ((q_data_r & U8_LEAD2_MSK) == U8_LEAD2_VAL) begin
                  seq_exp_nxt = 3'd2;
                end else if ((q_data_r & U8_LEAD3_MSK) == U8_LEAD3_VAL) begin
                  seq_exp_nxt = 3'd3;
                end else begin
                  seq_exp_nxt = 3'd4;
                end
                seq_bytes_nxt = 24'(q_data_r);
                seq_rec_nxt   = 3'd1;
              end
            end else if ((q_data_r & U8_CONT_MASK) != U8_CONT_VAL) begin
              // Broken sequence is dropped.
              seq_bytes_nxt = '0;
              seq_exp_nxt   = '0;
              seq_rec_nxt   = '0;
              res_bad_nxt   = 1'b1;
            end else if (seq_rec_r + 3'd1 >= seq_exp_r) begin
              // Last continuation byte completes the glyph.
              seq_bytes_nxt = '0;
              seq_exp_nxt   = '0;
              seq_rec_nxt   = '0;
              cell_we       = 1'b1;
              cell_waddr    = g_addr;
              cell_wdata    = '{bytes: comp_bytes, len: seq_exp_r, fg: pen_fg_r,
                                bg: pen_bg_r, chg: 1'b1};
              dirty_we      = 1'b1;
              dirty_waddr   = g_ring_row;
              if (col_inc >= eff_cols) begin
                cur_col_nxt = '0;
                cur_row_nxt = nr_row;
                ring_nxt    = nr_ring;
              end else begin
                cur_col_nxt = CW'(col_inc);
              end
            end else begin
              seq_bytes_nxt = comp_bytes[23:0];
              seq_rec_nxt   = seq_rec_r + 3'd1;
            end
          end else begin
            // Colour set: read the cell under the cursor, rewrite next cycle.
            if (q_type_r == REQ_FG) begin
              pen_fg_nxt = q_color_r;
            end else begin
              pen_bg_nxt = q_color_r;
            end
            addr_nxt   = g_addr;
            drow_nxt   = g_ring_row;
            cell_raddr = g_addr;
            state_nxt  = S_CWR;
          end
        end
      end
      S_RDW: begin
        if (rd_ok_r) begin
          res_cell_nxt   = cell_rdata;
          res_rowchg_nxt = dirty_rdata;
        end
        state_nxt = S_DONE;
      end
      S_CWR: begin
        cell_we    = 1'b1;
        cell_wdata = cell_rdata;
        cell_wdata.chg = 1'b1;
        if (q_type_r == REQ_FG) begin
          cell_wdata.fg = q_color_r;
        end else begin
          cell_wdata.bg = q_color_r;
        end
        dirty_we  = 1'b1;
        state_nxt = S_DONE;
      end
      S_NLRD: begin
        cell_raddr = nl_addr;
        state_nxt  = S_NLWR;
      end
      S_NLWR: begin
        // Blank one cell of the new row, keeping its colours.
        cell_we    = 1'b1;
        cell_waddr = nl_addr;
        cell_wdata = '{bytes: 32'(CH_SPACE), len: 3'd1, fg: cell_rdata.fg,
                       bg: cell_rdata.bg, chg: 1'b1};
        nl_j_nxt   = nl_j_r + ECW'(1);
        if (9'(nl_j_r) + 9'd1 >= eff_cols) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_NLRD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_cell_nxt   = res_cell_r;
          out_rowchg_nxt = res_rowchg_r;
          out_bad_nxt    = res_bad_r;
          out_row_nxt    = cur_row_r;
          out_col_nxt    = 7'(cur_col_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      cols_r      <= 8'd80;
      rows_r      <= 7'd24;
      ring_r      <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      pen_fg_r    <= '0;
      pen_bg_r    <= '0;
      seq_bytes_r <= '0;
      seq_exp_r   <= '0;
      seq_rec_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      ring_r      <= ring_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      pen_fg_r    <= pen_fg_nxt;
      pen_bg_r    <= pen_bg_nxt;
      seq_bytes_r <= seq_bytes_nxt;
      seq_exp_r   <= seq_exp_nxt;
      seq_rec_r   <= seq_rec_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_COLS: cols_r <= cfg_wdata;
          CFG_ROWS: rows_r <= cfg_wdata[6:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    nl_j_r       <= nl_j_nxt;
    addr_r       <= addr_nxt;
    drow_r       <= drow_nxt;
    rd_ok_r      <= rd_ok_nxt;
    res_cell_r   <= res_cell_nxt;
    res_rowchg_r <= res_rowchg_nxt;
    res_bad_r    <= res_bad_nxt;
    out_cell_r   <= out_cell_nxt;
    out_rowchg_r <= out_rowchg_nxt;
    out_bad_r    <= out_bad_nxt;
    out_row_r    <= out_row_nxt;
    out_col_r    <= out_col_nxt;
    if (accept) begin
      q_type_r  <= in_req_type;
      q_data_r  <= in_data_byte;
      q_color_r <= in_color;
      q_row_r   <= in_read_row;
      q_col_r   <= in_read_col;
    end
  end

  // Cell ring memory.
  tccw_ram #(
    .DW    (CELL_W),
    .DEPTH (DEPTH)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata_raw)
  );

  assign cell_rdata = cell_t'(cell_rdata_raw);

  // Row change marks.
  tccw_ram #(
    .DW    (1),
    .DEPTH (HISTORY_ROWS)
  ) u_dirty_ram (
    .clk   (clk),
    .we    (dirty_we),
    .waddr (dirty_waddr),
    .wdata (dirty_wdata),
    .raddr (dirty_raddr),
    .rdata (dirty_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_cell_bytes   = out_cell_r.bytes;
  assign out_cell_length  = out_cell_r.len;
  assign out_cell_fg      = out_cell_r.fg;
  assign out_cell_bg      = out_cell_r.bg;
  assign out_cell_changed = out_cell_r.chg;
  assign out_row_changed  = out_rowchg_r;
  assign out_cursor_row   = out_row_r;
  assign out_cursor_col   = out_col_r;
  assign out_bad_sequence = out_bad_r;

endmodule

@@ rtl/tccw_ram.sv @@
// Simple dual-port synchronous memory with one write and one registered read port.
module tccw_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ test/text_cell_canvas_writer_test.sv @@
// Self-checking testbench for the terminal character-cell writer.
module text_cell_canvas_writer_test;
  import tccw_pkg::*;

  localparam int HIST = 512;
  localparam int COLS_MAX = 128;
  localparam int WATCHDOG_LIMIT = 300000;

  // One input request and one expected cell-read result.
  typedef struct {
    logic [1:0] req;
    logic [7:0] data;
    logic [7:0] color;
    logic [5:0] row;
    logic [6:0] col;
  } request_t;

  typedef struct {
    logic [31:0] bytes;
    logic [2:0]  len;
    logic [7:0]  fg;
    logic [7:0]  bg;
    logic        chg;
    logic        row_chg;
    logic [5:0]  crow;
    logic [6:0]  ccol;
    logic        bad;
  } cell_view_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = '0;
  logic [7:0] in_data_byte = '0;
  logic [7:0] in_color = '0;
  logic [5:0] in_read_row = '0;
  logic [6:0] in_read_col = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_cell_bytes;
  logic [2:0] out_cell_length;
  logic [7:0] out_cell_fg;
  logic [7:0] out_cell_bg;
  logic out_cell_changed;
  logic out_row_changed;
  logic [5:0] out_cursor_row;
  logic [6:0] out_cursor_col;
  logic out_bad_sequence;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_COLS;
  logic [7:0] cfg_wdata = '0;

  text_cell_canvas_writer u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the screen state.
  cell_t canvas [HIST*COLS_MAX];
  bit row_marks [HIST];
  int ring_base, cur_row, cur_col, pen_fg, pen_bg;
  int utf_bytes, utf_need, utf_got;
  int cols_reg = 80, rows_reg = 24;

  request_t pending_reqs[$];
  cell_view_t expected_views[$];
  int fault_count = 0;
  int accepted_count = 0;
  int result_count = 0;
  int setting_count = 0;
  bit calm = 1'b0;

  function automatic int visible_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > COLS_MAX) return COLS_MAX;
    return cols_reg;
  endfunction

  function automatic int visible_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > 64) return 64;
    return rows_reg;
  endfunction

  function automatic void step_line();
    cur_col = 0;
    cur_row++;
    if (cur_row >= visible_rows()) begin
      ring_base = (ring_base + 1) % HIST;
      cur_row = visible_rows() - 1;
    end
  endfunction

  function automatic void place_glyph(int bytes, int len);
    int r, i;
    r = (ring_base + cur_row) % HIST;
    i = r * COLS_MAX + cur_col;
    canvas[i] = '{bytes: 32'(bytes), len: 3'(len), fg: 8'(pen_fg), bg: 8'(pen_bg),
                  chg: 1'b1};
    row_marks[r] = 1'b1;
    cur_col++;
    if (cur_col >= visible_cols()) step_line();
  endfunction

  // Works out the result of one accepted request and updates the shadow state.
  function automatic cell_view_t advance_canvas(request_t q);
    cell_view_t v;
    int r, i, d;
    v = '{default: '0};
    if (q.req == REQ_READ) begin
      r = (ring_base + q.row) % HIST;
      i = r * COLS_MAX + q.col;
      v.bytes = canvas[i].bytes;
      v.len = canvas[i].len;
      v.fg = canvas[i].fg;
      v.bg = canvas[i].bg;
      v.chg = canvas[i].chg;
      v.row_chg = row_marks[r];
    end else begin
      if (cur_col >= visible_cols()) cur_col = visible_cols() - 1;
      if (cur_row >= visible_rows()) cur_row = visible_rows() - 1;
      r = (ring_base + cur_row) % HIST;
      i = r * COLS_MAX + cur_col;
      d = q.data;
      if (q.req == REQ_FG || q.req == REQ_BG) begin
        canvas[i].chg = 1'b1;
        if (q.req == REQ_FG) begin
          canvas[i].fg = q.color;
          pen_fg = q.color;
        end else begin
          canvas[i].bg = q.color;
          pen_bg = q.color;
        end
        row_marks[r] = 1'b1;
      end else if (utf_need == 0) begin
        if (d >= 8'h80) begin
          if ((d & 8'he0) == 8'hc0) utf_need = 2;
          else if ((d & 8'hf0) == 8'he0) utf_need = 3;
          else utf_need = 4;
          utf_bytes = d;
          utf_got = 1;
        end else if (d == CH_BS) begin
          if (cur_col > 0) cur_col--;
        end else if (d == CH_CR) begin
          cur_col = 0;
        end else if (d == CH_LF) begin
          step_line();
          r = (ring_base + cur_row) % HIST;
          for (int j = 0; j < visible_cols(); j++) begin
            canvas[r*COLS_MAX + j].bytes = CH_SPACE;
            canvas[r*COLS_MAX + j].len = 3'd1;
            canvas[r*COLS_MAX + j].chg = 1'b1;
          end
        end else if (d != CH_NUL && d != CH_BEL && d != CH_TAB && d != CH_ESC) begin
          place_glyph(d, 1);
        end
      end else if ((d & 8'hc0) != 8'h80) begin
        // A non-continuation byte inside a sequence drops both.
        utf_bytes = 0;
        utf_need = 0;
        utf_got = 0;
        v.bad = 1'b1;
      end else if (utf_got + 1 >= utf_need) begin
        place_glyph(utf_bytes | (d << (8 * (utf_got & 3))), utf_need);
        utf_bytes = 0;
        utf_need = 0;
        utf_got = 0;
      end else begin
        utf_bytes = (utf_bytes | (d << (8 * (utf_got & 3)))) & 32'hffffff;
        utf_got++;
      end
    end
    v.crow = 6'(cur_row);
    v.ccol = 7'(cur_col);
    return v;
  endfunction

  // Request driver: predicts each accepted request, then offers the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_views.push_back(advance_canvas('{in_req_type, in_data_byte, in_color,
                                                 in_read_row, in_read_col}));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 32)) begin
          request_t q;
          q = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_req_type <= q.req;
          in_data_byte <= q.data;
          in_color <= q.color;
          in_read_row <= q.row;
          in_read_col <= q.col;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && $urandom_range(99) < 32;
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_views.size() == 0) begin
          $error("result with no request outstanding");
          fault_count++;
        end else begin
          cell_view_t e;
          e = expected_views.pop_front();
          if (out_cell_bytes !== e.bytes) begin
            $error("cell_bytes: expected %h, got %h", e.bytes, out_cell_bytes);
            fault_count++;
          end
          if (out_cell_length !== e.len) begin
            $error("cell_length: expected %0d, got %0d", e.len, out_cell_length);
            fault_count++;
          end
          if (out_cell_fg !== e.fg) begin
            $error("cell_fg: expected %0d, got %0d", e.fg, out_cell_fg);
            fault_count++;
          end
          if (out_cell_bg !== e.bg) begin
            $error("cell_bg: expected %0d, got %0d", e.bg, out_cell_bg);
            fault_count++;
          end
          if (out_cell_changed !== e.chg) begin
            $error("cell_changed: expected %0d, got %0d", e.chg, out_cell_changed);
            fault_count++;
          end
          if (out_row_changed !== e.row_chg) begin
            $error("row_changed: expected %0d, got %0d", e.row_chg, out_row_changed);
            fault_count++;
          end
          if (out_cursor_row !== e.crow) begin
            $error("cursor_row: expected %0d, got %0d", e.crow, out_cursor_row);
            fault_count++;
          end
          if (out_cursor_col !== e.ccol) begin
            $error("cursor_col: expected %0d, got %0d", e.ccol, out_cursor_col);
            fault_count++;
          end
          if (out_bad_sequence !== e.bad) begin
            $error("bad_sequence: expected %0d, got %0d", e.bad, out_bad_sequence);
            fault_count++;
          end
        end
      end
    end
  end

  // Watchdog: the reset clearing sweep alone is quiet, with no request or result moving.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("text_cell_canvas_writer: mismatch");
      $finish;
    end
  end

  task automatic queue_req(logic [1:0] req, logic [7:0] data, logic [7:0] color = 8'h00,
                           logic [5:0] row = 6'd0, logic [6:0] col = 7'd0);
    pending_reqs.push_back('{req, data, color, row, col});
  endtask

  task automatic write_reg(logic idx, logic [7:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_COLS) cols_reg = value;
    else rows_reg = value;
  endtask

  task automatic set_screen(logic [7:0] cols, logic [6:0] rows);
    write_reg(CFG_COLS, cols);
    write_reg(CFG_ROWS, {1'b0, rows});
    setting_count++;
  endtask

  // Waits until every request has its result, then for the longest newline.
  task automatic drain();
    while (pending_reqs.size() > 0 || expected_views.size() > 0 || in_valid)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Random traffic: mostly well-formed text, with controls, colours, reads and noise.
  task automatic queue_random(int n);
    int made, pick, len;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        len = $urandom_range(1, 4);
        case (len)
          1: queue_req(REQ_BYTE, $urandom_range(8'h20, 8'h7f));
          2: queue_req(REQ_BYTE, $urandom_range(8'hc0, 8'hdf));
          3: queue_req(REQ_BYTE, $urandom_range(8'he0, 8'hef));
          default: queue_req(REQ_BYTE, $urandom_range(8'hf0, 8'hff));
        endcase
        for (int k = 1; k < len; k++) queue_req(REQ_BYTE, $urandom_range(8'h80, 8'hbf));
        made += len;
      end else begin
        if (pick < 58) begin
          case ($urandom_range(6))
            0: queue_req(REQ_BYTE, CH_NUL);
            1: queue_req(REQ_BYTE, CH_BEL);
            2: queue_req(REQ_BYTE, CH_TAB);
            3: queue_req(REQ_BYTE, CH_ESC);
            4: queue_req(REQ_BYTE, CH_BS);
            5: queue_req(REQ_BYTE, CH_CR);
            default: queue_req(REQ_BYTE, CH_LF);
          endcase
        end else if (pick < 66) begin
          queue_req(REQ_BYTE, $urandom_range(255), $urandom_range(255));
        end else if (pick < 74) begin
          queue_req($urandom_range(1) ? REQ_FG : REQ_BG, $urandom_range(255),
                    $urandom_range(255));
        end else if (pick < 88) begin
          queue_req(REQ_READ, $urandom_range(255), 8'h00,
                    $urandom_range(visible_rows() - 1), $urandom_range(visible_cols() - 1));
        end else begin
          queue_req(REQ_READ, $urandom_range(255), $urandom_range(255),
                    $urandom_range(63), $urandom_range(127));
        end
        made++;
      end
    end
  endtask

  initial begin
    // The cell store starts all zero after reset.
    foreach (canvas[k]) canvas[k] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    set_screen(8'd80, 7'd24);

    // Directed: colours, every sequence length, broken sequences and controls.
    queue_req(REQ_FG, 8'h00, 8'hff);
    queue_req(REQ_BG, 8'h00, 8'h00);
    queue_req(REQ_BYTE, 8'h41);
    queue_req(REQ_BYTE, 8'hc3);
    queue_req(REQ_BYTE, 8'ha9);
    queue_req(REQ_BYTE, 8'he2);
    queue_req(REQ_BYTE, 8'h82);
    queue_req(REQ_READ, 8'h00, 8'h00, 6'd0, 7'd1);
    queue_req(REQ_BYTE, 8'hac);
    queue_req(REQ_BYTE, 8'hff);
    queue_req(REQ_BYTE, 8'hbf);
    queue_req(REQ_BYTE, 8'h80);
    queue_req(REQ_BYTE, 8'hbf);
    queue_req(REQ_BYTE, 8'hc3);
    queue_req(REQ_BYTE, 8'h41);
    queue_req(REQ_BYTE, CH_NUL);
    queue_req(REQ_BYTE, CH_BEL);
    queue_req(REQ_BYTE, CH_TAB);
    queue_req(REQ_BYTE, CH_ESC);
    queue_req(REQ_BYTE, CH_BS);
    queue_req(REQ_BYTE, CH_CR);
    queue_req(REQ_BYTE, CH_BS);
    queue_req(REQ_BYTE, CH_LF);
    queue_req(REQ_READ, 8'h00, 8'h00, 6'd0, 7'd3);
    queue_req(REQ_READ, 8'h00, 8'h00, 6'd63, 7'd127);
    drain();

    // Shrink under the cursor so that it is clamped.
    set_screen(8'd0, 7'd0);
    queue_req(REQ_BYTE, 8'h5a);
    queue_req(REQ_READ, 8'h00, 8'h00, 6'd0, 7'd0);
    drain();

    // Random phases over a range of screen sizes, extremes among them.
    set_screen(8'd1, 7'd1);
    queue_random(150);
    drain();
    set_screen(8'd255, 7'd127);
    queue_random(200);
    drain();
    set_screen(8'd128, 7'd64);
    calm = 1'b1;
    queue_random(250);
    drain();
    calm = 1'b0;
    set_screen(8'd7, 7'd3);
    queue_random(300);
    drain();
    set_screen(8'd129, 7'd65);
    queue_random(150);
    drain();
    set_screen(8'd16, 7'd5);
    queue_random(300);
    drain();
    set_screen(8'd40, 7'd2);
    queue_random(300);
    drain();

    $display("Covered %0d requests and %0d results over %0d screen sizes.",
             accepted_count, result_count, setting_count);
    if (fault_count == 0 && expected_views.size() == 0) begin
      $display("text_cell_canvas_writer: match");
    end else begin
      $display("text_cell_canvas_writer: mismatch");
    end
    $finish;
  end

endmodule
